// File: rtl/core/csep_pkg.sv
// shared types, constants and helpers of the crowd separation steering block
package csep_pkg;

  localparam int MAX_AGENTS = 64;
  localparam int IDX_W      = $clog2(MAX_AGENTS);
  localparam int CNT_W      = IDX_W + 1;

  localparam int RAD_W      = 23;
  localparam int STR_W      = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 23;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_STRENGTH = 1'b1;

  localparam logic [RAD_W-1:0] RADIUS_RESET   = 23'd256;
  localparam logic [STR_W-1:0] STRENGTH_RESET = 16'd256;

  localparam logic signed [15:0] Q_ONE = 16'sd16384;
  localparam logic signed [15:0] DIAG  = 16'sd11585;

  typedef struct packed {
    logic [31:0]        actor_id;
    logic signed [23:0] position_x;
    logic signed [23:0] position_y;
    logic signed [15:0] desired_x;
    logic signed [15:0] desired_y;
    logic               final_agent;
  } in_item_t;

  typedef struct packed {
    logic [31:0]        steer_actor;
    logic signed [15:0] steer_x;
    logic signed [15:0] steer_y;
    logic               was_separated;
    logic               final_steer;
  } out_item_t;

  // one stored agent record
  typedef struct packed {
    logic [31:0]        actor_id;
    logic signed [23:0] position_x;
    logic signed [23:0] position_y;
    logic signed [15:0] desired_x;
    logic signed [15:0] desired_y;
  } agent_t;

  localparam int AGENT_W = $bits(agent_t);

  typedef enum logic [5:0] {
    OP_NOP, OP_LOAD, OP_RR, OP_RR_SAVE, OP_RD_OWN, OP_LAT_OWN,
    OP_N_SHIFT, OP_N_ZERO, OP_N_SQX, OP_N_SQY, OP_N_SQS, OP_SQ_STEP,
    OP_N_DVX, OP_DV_STEP, OP_N_DVY, OP_N_FIN0, OP_N_FIN1,
    OP_P_RD, OP_P_DIFF, OP_P_MX, OP_P_MY, OP_P_FAN, OP_P_SQS,
    OP_P_DUX, OP_P_DUY, OP_P_DW, OP_P_MUX, OP_P_MUY, OP_P_ADY, OP_INC_J,
    OP_B_MX, OP_B_MY, OP_B_LD, OP_EMIT
  } op_t;

  typedef enum logic [5:0] {
    S_IDLE, S_RR, S_RR_SAVE, S_RD_OWN, S_LAT_OWN,
    S_N_SHIFT, S_N_SQX, S_N_SQY, S_N_SQS, S_N_SQRT,
    S_N_DVX, S_N_DVXL, S_N_DVY, S_N_DVYL, S_N_FIN,
    S_P_RD, S_P_DIFF, S_P_MX, S_P_MY, S_P_D2, S_P_SQRT,
    S_P_DUX, S_P_DUXL, S_P_DUY, S_P_DUYL, S_P_DW, S_P_DWL,
    S_P_MUX, S_P_MUY, S_P_ADY, S_P_NEXT,
    S_B_CHK, S_B_MX, S_B_MY, S_B_LD, S_EMIT
  } state_t;

  typedef struct packed {
    logic n_zero;
    logic n_inrange;
    logic sq_last;
    logic dv_last;
    logic j_is_i;
    logic j_last;
    logic i_last;
    logic active;
    logic push_nz;
    logic close;
    logic d2_zero;
  } status_t;

  // eighth-turn unit vectors for coincident agents
  function automatic logic signed [15:0] fan_x(input logic [2:0] k);
    case (k)
      3'd0: fan_x = Q_ONE;
      3'd1: fan_x = DIAG;
      3'd2: fan_x = 16'sd0;
      3'd3: fan_x = -DIAG;
      3'd4: fan_x = -Q_ONE;
      3'd5: fan_x = -DIAG;
      3'd6: fan_x = 16'sd0;
      default: fan_x = DIAG;
    endcase
  endfunction

  function automatic logic signed [15:0] fan_y(input logic [2:0] k);
    case (k)
      3'd0: fan_y = 16'sd0;
      3'd1: fan_y = DIAG;
      3'd2: fan_y = Q_ONE;
      3'd3: fan_y = DIAG;
      3'd4: fan_y = 16'sd0;
      3'd5: fan_y = -DIAG;
      3'd6: fan_y = -Q_ONE;
      default: fan_y = -DIAG;
    endcase
  endfunction

endpackage

// File: rtl/core/crowd_separation_steering.sv
// top level of the crowd separation steering block
//
//  channel | handshake              | payload
//  --------+------------------------+-------------------------
//  in      | start, busy            | in_data   (in_item_t)
//  out     | out_valid (strobe)     | out_data  (out_item_t)
//  cfg     | cfg_valid, cfg_ready   | cfg_index, cfg_data
//
// a load transaction writes the agent record to a 64-entry ram
// the final transaction starts the scan; per agent the direction is normalized
// by one-bit shifts, a 32-step root and two 17-step divisions; a close pair
// takes a 32-step root plus three 17-step divisions on one shared unit, and
// a pushed agent is normalized once more
// busy stays high until the last steer; steers never come in adjacent cycles
// synchronous active-low reset clears control state; cfg_ready is always high
module crowd_separation_steering (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  csep_pkg::in_item_t                in_data,
  output logic                              out_valid,
  output csep_pkg::out_item_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [csep_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [csep_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import csep_pkg::*;

  logic [RAD_W-1:0] radius_r;
  logic [STR_W-1:0] strength_r;
  op_t              op;
  status_t          status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r   <= RADIUS_RESET;
      strength_r <= STRENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RADIUS:   radius_r   <= cfg_data[RAD_W-1:0];
        REG_STRENGTH: strength_r <= cfg_data[STR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  csep_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_final  (in_data.final_agent),
    .status    (status),
    .op        (op),
    .busy      (busy),
    .out_valid (out_valid)
  );

  csep_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (op),
    .in_data  (in_data),
    .radius   (radius_r),
    .strength (strength_r),
    .status   (status),
    .out_data (out_data)
  );

endmodule

// File: rtl/core/csep_ram.sv
// generic single-write, single-read ram with registered read data
module csep_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/csep_dp.sv
// datapath: agent store, shared multiplier, iterative root, divider and normalizer
module csep_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  csep_pkg::op_t                   op,
  input  csep_pkg::in_item_t              in_data,
  input  logic [csep_pkg::RAD_W-1:0]      radius,
  input  logic [csep_pkg::STR_W-1:0]      strength,
  output csep_pkg::status_t               status,
  output csep_pkg::out_item_t             out_data
);
  import csep_pkg::*;

  logic [CNT_W-1:0] cnt_r;
  logic [IDX_W-1:0] i_r, j_r;
  logic [45:0]      rr_r;
  agent_t           own_r, rag;
  logic [AGENT_W-1:0] ram_rdata;
  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_raddr;

  logic signed [63:0] prod_r, hold_r, mul_p;
  logic signed [31:0] mul_a, mul_b;
  logic signed [24:0] dx_r, dy_r;
  logic [33:0]        ax_r, ay_r, n_max;
  logic               nsx_r, nsy_r;
  logic [63:0]        sq_in_r;
  logic [35:0]        sq_rem_r, sq_rem2, sq_trial;
  logic [31:0]        sq_root_r;
  logic [4:0]         sq_cnt_r;
  logic [47:0]        dv_num_r, dv_trial;
  logic [31:0]        dv_den_r;
  logic [16:0]        dv_q_r;
  logic [4:0]         dv_k_r;
  logic signed [17:0] qx_r, q_s, dx0_r, dy0_r, sx_r, sy_r, ux_r, uy_r;
  logic signed [23:0] px_r, py_r, r14_s;
  logic signed [33:0] bx_r, r8_s, load_x, load_y;
  logic               sep_r;
  out_item_t          out_r;

  logic [63:0] sum64, pmag, rnd14, rnd8;
  logic [30:0] r256;
  logic [24:0] mag_dx, mag_dy;
  logic signed [15:0] fx, fy;

  assign rag       = agent_t'(ram_rdata);
  assign ram_we    = (op == OP_LOAD) && (cnt_r < CNT_W'(MAX_AGENTS));
  assign ram_re    = (op == OP_RD_OWN) || (op == OP_P_RD);
  assign ram_raddr = (op == OP_P_RD) ? j_r : i_r;

  csep_ram #(.WIDTH(AGENT_W), .DEPTH(MAX_AGENTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[IDX_W-1:0]),
    .wdata ({in_data.actor_id, in_data.position_x, in_data.position_y,
             in_data.desired_x, in_data.desired_y}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign r256   = {radius, 8'b0};
  assign sum64  = $unsigned(hold_r) + $unsigned(prod_r);
  assign pmag   = prod_r[63] ? $unsigned(-prod_r) : $unsigned(prod_r);
  assign rnd14  = pmag + 64'd8192;
  assign rnd8   = pmag + 64'd128;
  assign r14_s  = prod_r[63] ? -$signed(rnd14[37:14]) : $signed(rnd14[37:14]);
  assign r8_s   = prod_r[63] ? -$signed(rnd8[41:8]) : $signed(rnd8[41:8]);
  assign mag_dx = dx_r[24] ? $unsigned(-dx_r) : $unsigned(dx_r);
  assign mag_dy = dy_r[24] ? $unsigned(-dy_r) : $unsigned(dy_r);
  assign n_max  = (ax_r > ay_r) ? ax_r : ay_r;
  assign q_s    = nsy_r ? -$signed({1'b0, dv_q_r}) : $signed({1'b0, dv_q_r});
  assign fx     = fan_x(i_r[2:0]);
  assign fy     = fan_y(i_r[2:0]);

  assign sq_rem2  = {sq_rem_r[33:0], sq_in_r[63:62]};
  assign sq_trial = {2'b0, sq_root_r, 2'b01};
  assign dv_trial = 48'(dv_den_r) << dv_k_r;

  // shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op)
      OP_RR:    begin mul_a = $signed({9'b0, radius}); mul_b = mul_a; end
      OP_N_SQX: begin mul_a = $signed(ax_r[31:0]); mul_b = mul_a; end
      OP_N_SQY: begin mul_a = $signed(ay_r[31:0]); mul_b = mul_a; end
      OP_P_MX:  begin mul_a = 32'(dx_r); mul_b = mul_a; end
      OP_P_MY:  begin mul_a = 32'(dy_r); mul_b = mul_a; end
      OP_P_MUX: begin mul_a = 32'(ux_r); mul_b = $signed({15'b0, dv_q_r}); end
      OP_P_MUY: begin mul_a = 32'(uy_r); mul_b = $signed({15'b0, dv_q_r}); end
      OP_B_MX:  begin mul_a = 32'(px_r); mul_b = $signed({16'b0, strength}); end
      OP_B_MY:  begin mul_a = 32'(py_r); mul_b = $signed({16'b0, strength}); end
      default:  begin mul_a = '0; mul_b = '0; end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // vector entering the normalizer
  always_comb begin
    load_x = '0;
    load_y = '0;
    case (op)
      OP_LAT_OWN: begin
        load_x = 34'(rag.desired_x);
        load_y = 34'(rag.desired_y);
      end
      OP_B_LD: begin
        load_x = bx_r;
        load_y = 34'(dy0_r) + r8_s;
      end
      default: begin
        load_x = '0;
        load_y = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      i_r   <= '0;
      j_r   <= '0;
    end else begin
      unique case (op)
        OP_LOAD: begin
          if (cnt_r < CNT_W'(MAX_AGENTS)) cnt_r <= cnt_r + CNT_W'(1);
        end
        OP_RR:      i_r <= '0;
        OP_LAT_OWN: j_r <= '0;
        OP_INC_J:   j_r <= j_r + IDX_W'(1);
        OP_EMIT: begin
          if (status.i_last) cnt_r <= '0;
          else i_r <= i_r + IDX_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (op)
      OP_RR:      prod_r <= mul_p;
      OP_RR_SAVE: rr_r <= prod_r[45:0];
      OP_LAT_OWN: begin
        own_r <= rag;
        ax_r  <= load_x[33] ? $unsigned(-load_x) : $unsigned(load_x);
        ay_r  <= load_y[33] ? $unsigned(-load_y) : $unsigned(load_y);
        nsx_r <= load_x[33];
        nsy_r <= load_y[33];
        px_r  <= '0;
        py_r  <= '0;
        sep_r <= 1'b0;
      end
      OP_B_LD: begin
        ax_r  <= load_x[33] ? $unsigned(-load_x) : $unsigned(load_x);
        ay_r  <= load_y[33] ? $unsigned(-load_y) : $unsigned(load_y);
        nsx_r <= load_x[33];
        nsy_r <= load_y[33];
      end
      OP_N_SHIFT: begin
        // one bit a cycle until the larger magnitude sits in [2^29, 2^30)
        if (|n_max[33:30]) begin
          ax_r <= ax_r >> 1;
          ay_r <= ay_r >> 1;
        end else begin
          ax_r <= ax_r << 1;
          ay_r <= ay_r << 1;
        end
      end
      OP_N_ZERO: begin
        qx_r   <= '0;
        dv_q_r <= '0;
      end
      OP_N_SQX: prod_r <= mul_p;
      OP_N_SQY: begin
        hold_r <= prod_r;
        prod_r <= mul_p;
      end
      OP_N_SQS: begin
        sq_in_r   <= sum64;
        sq_rem_r  <= '0;
        sq_root_r <= '0;
        sq_cnt_r  <= '0;
      end
      OP_SQ_STEP: begin
        if (sq_rem2 >= sq_trial) begin
          sq_rem_r  <= sq_rem2 - sq_trial;
          sq_root_r <= {sq_root_r[30:0], 1'b1};
        end else begin
          sq_rem_r  <= sq_rem2;
          sq_root_r <= {sq_root_r[30:0], 1'b0};
        end
        sq_in_r  <= sq_in_r << 2;
        sq_cnt_r <= sq_cnt_r + 5'd1;
      end
      OP_N_DVX: begin
        dv_num_r <= (48'(ax_r[29:0]) << 14) + 48'(sq_root_r[31:1]);
        dv_den_r <= sq_root_r;
        dv_q_r   <= '0;
        dv_k_r   <= 5'd16;
      end
      OP_DV_STEP: begin
        if (dv_num_r >= dv_trial) begin
          dv_num_r <= dv_num_r - dv_trial;
          dv_q_r   <= dv_q_r | (17'd1 << dv_k_r);
        end
        dv_k_r <= dv_k_r - 5'd1;
      end
      OP_N_DVY: begin
        qx_r     <= nsx_r ? -$signed({1'b0, dv_q_r}) : $signed({1'b0, dv_q_r});
        dv_num_r <= (48'(ay_r[29:0]) << 14) + 48'(sq_root_r[31:1]);
        dv_den_r <= sq_root_r;
        dv_q_r   <= '0;
        dv_k_r   <= 5'd16;
      end
      OP_N_FIN0: begin
        dx0_r <= qx_r;
        dy0_r <= q_s;
        sx_r  <= qx_r;
        sy_r  <= q_s;
      end
      OP_N_FIN1: begin
        sx_r <= qx_r;
        sy_r <= q_s;
      end
      OP_P_DIFF: begin
        dx_r <= 25'(own_r.position_x) - 25'(rag.position_x);
        dy_r <= 25'(own_r.position_y) - 25'(rag.position_y);
      end
      OP_P_MX: prod_r <= mul_p;
      OP_P_MY: begin
        hold_r <= prod_r;
        prod_r <= mul_p;
      end
      OP_P_FAN: begin
        px_r <= px_r + 24'(fx);
        py_r <= py_r + 24'(fy);
      end
      OP_P_SQS: begin
        sq_in_r   <= sum64 << 16;
        sq_rem_r  <= '0;
        sq_root_r <= '0;
        sq_cnt_r  <= '0;
      end
      OP_P_DUX: begin
        dv_num_r <= (48'(mag_dx) << 22) + 48'(sq_root_r[31:1]);
        dv_den_r <= sq_root_r;
        dv_q_r   <= '0;
        dv_k_r   <= 5'd16;
      end
      OP_P_DUY: begin
        ux_r     <= dx_r[24] ? -$signed({1'b0, dv_q_r}) : $signed({1'b0, dv_q_r});
        dv_num_r <= (48'(mag_dy) << 22) + 48'(sq_root_r[31:1]);
        dv_den_r <= sq_root_r;
        dv_q_r   <= '0;
        dv_k_r   <= 5'd16;
      end
      OP_P_DW: begin
        // falloff weight, distance is always below the radius here
        uy_r     <= dy_r[24] ? -$signed({1'b0, dv_q_r}) : $signed({1'b0, dv_q_r});
        dv_num_r <= (48'(r256 - sq_root_r[30:0]) << 14) + 48'(r256[30:1]);
        dv_den_r <= {1'b0, r256};
        dv_q_r   <= '0;
        dv_k_r   <= 5'd16;
      end
      OP_P_MUX: prod_r <= mul_p;
      OP_P_MUY: begin
        px_r   <= px_r + r14_s;
        prod_r <= mul_p;
      end
      OP_P_ADY: py_r <= py_r + r14_s;
      OP_B_MX: begin
        sep_r  <= 1'b1;
        prod_r <= mul_p;
      end
      OP_B_MY: begin
        bx_r   <= 34'(dx0_r) + r8_s;
        prod_r <= mul_p;
      end
      OP_EMIT: begin
        out_r.steer_actor   <= own_r.actor_id;
        out_r.steer_x       <= sx_r[15:0];
        out_r.steer_y       <= sy_r[15:0];
        out_r.was_separated <= sep_r;
        out_r.final_steer   <= status.i_last;
      end
      default: begin
      end
    endcase
  end

  assign status.n_zero    = (ax_r == '0) && (ay_r == '0);
  assign status.n_inrange = (n_max[33:30] == '0) && n_max[29];
  assign status.sq_last   = (sq_cnt_r == 5'd31);
  assign status.dv_last   = (dv_k_r == 5'd0);
  assign status.j_is_i    = (j_r == i_r);
  assign status.j_last    = (CNT_W'(j_r) + CNT_W'(1)) == cnt_r;
  assign status.i_last    = (CNT_W'(i_r) + CNT_W'(1)) == cnt_r;
  assign status.active    = (cnt_r >= CNT_W'(2)) && (radius != '0);
  assign status.push_nz   = (px_r != '0) || (py_r != '0);
  assign status.close     = sum64 < 64'(rr_r);
  assign status.d2_zero   = (sum64 == '0);

  assign out_data = out_r;

endmodule

// File: rtl/core/csep_ctrl.sv
// sequencer: steps the datapath through loading, normalize, pair scan, blend and emit
module csep_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              in_final,
  input  csep_pkg::status_t status,
  output csep_pkg::op_t     op,
  output logic              busy,
  output logic              out_valid
);
  import csep_pkg::*;

  state_t state_r, state_nxt;
  logic   phase_r, phase_nxt;
  logic   out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= (state_r == S_EMIT);
    end
  end

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    op        = OP_NOP;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op = OP_LOAD;
          if (in_final) state_nxt = S_RR;
        end
      end
      S_RR:      begin op = OP_RR;      state_nxt = S_RR_SAVE; end
      S_RR_SAVE: begin op = OP_RR_SAVE; state_nxt = S_RD_OWN;  end
      S_RD_OWN:  begin op = OP_RD_OWN;  state_nxt = S_LAT_OWN; end
      S_LAT_OWN: begin
        op        = OP_LAT_OWN;
        phase_nxt = 1'b0;
        state_nxt = S_N_SHIFT;
      end
      S_N_SHIFT: begin
        if (status.n_zero) begin
          op        = OP_N_ZERO;
          state_nxt = S_N_FIN;
        end else if (status.n_inrange) begin
          state_nxt = S_N_SQX;
        end else begin
          op = OP_N_SHIFT;
        end
      end
      S_N_SQX: begin op = OP_N_SQX; state_nxt = S_N_SQY; end
      S_N_SQY: begin op = OP_N_SQY; state_nxt = S_N_SQS; end
      S_N_SQS: begin op = OP_N_SQS; state_nxt = S_N_SQRT; end
      S_N_SQRT: begin
        op = OP_SQ_STEP;
        if (status.sq_last) state_nxt = S_N_DVX;
      end
      S_N_DVX: begin op = OP_N_DVX; state_nxt = S_N_DVXL; end
      S_N_DVXL: begin
        op = OP_DV_STEP;
        if (status.dv_last) state_nxt = S_N_DVY;
      end
      S_N_DVY: begin op = OP_N_DVY; state_nxt = S_N_DVYL; end
      S_N_DVYL: begin
        op = OP_DV_STEP;
        if (status.dv_last) state_nxt = S_N_FIN;
      end
      S_N_FIN: begin
        if (phase_r) begin
          op        = OP_N_FIN1;
          state_nxt = S_EMIT;
        end else begin
          op        = OP_N_FIN0;
          state_nxt = status.active ? S_P_RD : S_EMIT;
        end
      end
      S_P_RD: begin
        if (status.j_is_i) begin
          state_nxt = S_P_NEXT;
        end else begin
          op        = OP_P_RD;
          state_nxt = S_P_DIFF;
        end
      end
      S_P_DIFF: begin op = OP_P_DIFF; state_nxt = S_P_MX; end
      S_P_MX:   begin op = OP_P_MX;   state_nxt = S_P_MY; end
      S_P_MY:   begin op = OP_P_MY;   state_nxt = S_P_D2; end
      S_P_D2: begin
        if (!status.close) begin
          state_nxt = S_P_NEXT;
        end else if (status.d2_zero) begin
          op        = OP_P_FAN;
          state_nxt = S_P_NEXT;
        end else begin
          op        = OP_P_SQS;
          state_nxt = S_P_SQRT;
        end
      end
      S_P_SQRT: begin
        op = OP_SQ_STEP;
        if (status.sq_last) state_nxt = S_P_DUX;
      end
      S_P_DUX: begin op = OP_P_DUX; state_nxt = S_P_DUXL; end
      S_P_DUXL: begin
        op = OP_DV_STEP;
        if (status.dv_last) state_nxt = S_P_DUY;
      end
      S_P_DUY: begin op = OP_P_DUY; state_nxt = S_P_DUYL; end
      S_P_DUYL: begin
        op = OP_DV_STEP;
        if (status.dv_last) state_nxt = S_P_DW;
      end
      S_P_DW: begin op = OP_P_DW; state_nxt = S_P_DWL; end
      S_P_DWL: begin
        op = OP_DV_STEP;
        if (status.dv_last) state_nxt = S_P_MUX;
      end
      S_P_MUX: begin op = OP_P_MUX; state_nxt = S_P_MUY; end
      S_P_MUY: begin op = OP_P_MUY; state_nxt = S_P_ADY; end
      S_P_ADY: begin op = OP_P_ADY; state_nxt = S_P_NEXT; end
      S_P_NEXT: begin
        if (status.j_last) begin
          state_nxt = S_B_CHK;
        end else begin
          op        = OP_INC_J;
          state_nxt = S_P_RD;
        end
      end
      S_B_CHK: state_nxt = status.push_nz ? S_B_MX : S_EMIT;
      S_B_MX:  begin op = OP_B_MX; state_nxt = S_B_MY; end
      S_B_MY:  begin op = OP_B_MY; state_nxt = S_B_LD; end
      S_B_LD: begin
        op        = OP_B_LD;
        phase_nxt = 1'b1;
        state_nxt = S_N_SHIFT;
      end
      S_EMIT: begin
        op        = OP_EMIT;
        state_nxt = status.i_last ? S_IDLE : S_RD_OWN;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: rtl/core/csep_checker.sv
// port-level checks of the crowd separation steering block, with bind
module csep_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input csep_pkg::in_item_t                in_data,
  input logic                              out_valid,
  input csep_pkg::out_item_t               out_data
);

  // a final transaction always starts the scan
  a_final_starts: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_data.final_agent |=> busy)
    else $error("final transaction did not start the scan");

  // steers never come in adjacent cycles
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("steers in adjacent cycles");

  // only the last steer comes with the block idle again
  a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.final_steer == !busy))
    else $error("final_steer does not match the end of the scan");

  // the scan ends only with the last steer
  a_end_steer: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid && out_data.final_steer)
    else $error("scan ended without its last steer");

endmodule

bind crowd_separation_steering csep_checker u_csep_checker (.*);
